### hdl/fixed_block_pool_allocator_core_macros.svh
// assertion macros for the pool allocator checker
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define FBPA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FBPA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

   // commands carried in req_tuser
   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
   localparam logic [1:0] REG_BLOCK_BYTES  = 2'd1;
   localparam logic [1:0] REG_ALIGNMENT    = 2'd2;
   localparam logic [1:0] REG_BLOCK_COUNT  = 2'd3;

   // configuration reset values
   localparam logic [31:0] RST_BASE_ADDRESS = 32'd0;
   localparam logic [7:0]  RST_BLOCK_BYTES  = 8'd16;
   localparam logic [7:0]  RST_ALIGNMENT    = 8'd8;
   localparam logic [8:0]  RST_BLOCK_COUNT  = 9'd256;

   // link encoding: bit 8 set marks the end of the free list
   localparam logic [8:0] LINK_END = 9'h100;

   // indexes are eight bits, so at most this many blocks are ever linked
   localparam int unsigned LINK_SPAN = 256;

   localparam int unsigned DEFAULT_NUM_BLOCKS = 256;

   // settings seen by the allocator datapath
   typedef struct packed {
      logic [31:0] aligned_base;
      logic [7:0]  block_bytes;
      logic [8:0]  eff_count;
   } cfg_type;

endpackage

`default_nettype wire

### hdl/fixed_block_pool_allocator_core.sv
// sequence: free, no-op and failed allocate go from idle to done; a granted allocate
// passes the allocate state first; init writes one link memory entry per block
// throughput: one command at a time, the next is accepted once back in idle;
// a finished result waits in the output register while the next command runs
// reset: synchronous, clears control, counts and configuration; the free list
// is empty until an init or a free command adds blocks
`default_nettype none

module fixed_block_pool_allocator_core
   import fbpa_pkg::*;
#(
   parameter int unsigned NUM_BLOCKS = DEFAULT_NUM_BLOCKS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] block_index
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] granted_index, [39:8] granted_address, [48:40] live_blocks,
   // [64:49] live_bytes, [71:65] zero
   output logic [71:0]      rsp_tdata,
   output logic             rsp_tuser,   // [0] status
   // configuration writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int unsigned MEM_DEPTH = (NUM_BLOCKS < LINK_SPAN) ? NUM_BLOCKS : LINK_SPAN;
   localparam int unsigned AW        = $clog2(MEM_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_INIT = 2'd1;
   localparam logic [1:0] ST_ALOC = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   cfg_type cfg;

   logic [1:0]  state_ff, state_in;
   logic [8:0]  head_ff, head_in;
   logic [8:0]  live_cnt_ff, live_cnt_in;
   logic [15:0] live_bytes_ff, live_bytes_in;
   logic [8:0]  init_cnt_ff, init_cnt_in;
   logic        status_ff, status_in;
   logic [7:0]  gidx_ff, gidx_in;
   logic [31:0] gaddr_ff, gaddr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_status_ff, rsp_status_in;
   logic [71:0] rsp_data_ff, rsp_data_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [8:0]    wr_data;
   logic [8:0]    rd_data;

   logic          req_fire;
   logic [9:0]    init_next;
   logic [15:0]   product;
   logic [16:0]   bytes_sum;
   logic          slot_free;

   fbpa_csr #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // the head entry is read every cycle; writes and the allocate read never
   // overlap because the sequencer runs one command at a time
   fbpa_link_mem #(
      .DEPTH (MEM_DEPTH),
      .AW    (AW)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (head_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign init_next  = {1'b0, init_cnt_ff} + 10'd1;
   assign product    = 16'(head_ff[7:0]) * 16'(cfg.block_bytes);
   assign bytes_sum  = {1'b0, live_bytes_ff} + 17'(cfg.block_bytes);

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      live_cnt_in   = live_cnt_ff;
      live_bytes_in = live_bytes_ff;
      init_cnt_in   = init_cnt_ff;
      status_in     = status_ff;
      gidx_in       = gidx_ff;
      gaddr_in      = gaddr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = init_cnt_ff[AW-1:0];
      wr_data       = LINK_END;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               status_in = 1'b0;
               gidx_in   = 8'd0;
               gaddr_in  = 32'd0;
               state_in  = ST_DONE;
               unique case (req_tuser)
                  CMD_INIT: begin
                     live_cnt_in   = 9'd0;
                     live_bytes_in = 16'd0;
                     init_cnt_in   = 9'd0;
                     head_in       = LINK_END;
                     if (cfg.eff_count != 9'd0) state_in = ST_INIT;
                  end
                  CMD_ALLOC: begin
                     if (head_ff[8]) status_in = 1'b1;
                     else            state_in  = ST_ALOC;
                  end
                  CMD_FREE: begin
                     if ({1'b0, req_tdata} < cfg.eff_count) begin
                        wr_en         = 1'b1;
                        wr_addr       = req_tdata[AW-1:0];
                        wr_data       = head_ff;
                        head_in       = {1'b0, req_tdata};
                        live_cnt_in   = (live_cnt_ff != 9'd0) ? live_cnt_ff - 9'd1 : 9'd0;
                        live_bytes_in = (live_bytes_ff > 16'(cfg.block_bytes))
                                        ? live_bytes_ff - 16'(cfg.block_bytes) : 16'd0;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         // link block i to block i+1, the last one ends the list
         ST_INIT: begin
            wr_en       = 1'b1;
            wr_addr     = init_cnt_ff[AW-1:0];
            init_cnt_in = init_next[8:0];
            if (init_next < {1'b0, cfg.eff_count}) begin
               wr_data = init_next[8:0];
            end else begin
               wr_data  = LINK_END;
               head_in  = 9'd0;
               state_in = ST_DONE;
            end
         end
         // link read of the head is back: pop it
         ST_ALOC: begin
            gidx_in       = head_ff[7:0];
            gaddr_in      = cfg.aligned_base + 32'(product);
            head_in       = rd_data;
            live_cnt_in   = (live_cnt_ff != 9'h1FF) ? live_cnt_ff + 9'd1 : live_cnt_ff;
            live_bytes_in = bytes_sum[16] ? 16'hFFFF : bytes_sum[15:0];
            state_in      = ST_DONE;
         end
         // hand the result to the output register
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = {7'd0, live_bytes_ff, live_cnt_ff, gaddr_ff, gidx_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= LINK_END;
         live_cnt_ff   <= 9'd0;
         live_bytes_ff <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         live_cnt_ff   <= live_cnt_in;
         live_bytes_ff <= live_bytes_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      init_cnt_ff   <= init_cnt_in;
      status_ff     <= status_in;
      gidx_ff       <= gidx_in;
      gaddr_ff      <= gaddr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### hdl/fbpa_csr.sv
`default_nettype none

module fbpa_csr
   import fbpa_pkg::*;
#(
   parameter int unsigned MEM_DEPTH = LINK_SPAN
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   output cfg_type          cfg
);

   localparam logic [8:0] DEPTH_CAP = 9'(MEM_DEPTH);

   logic [31:0] base_ff, base_in;
   logic [7:0]  bytes_ff, bytes_in;
   logic [7:0]  align_ff, align_in;
   logic [8:0]  count_ff, count_in;
   logic [31:0] aligned_ff, aligned_in;
   logic [2:0]  msb;
   logic [7:0]  mask;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      base_in  = base_ff;
      bytes_in = bytes_ff;
      align_in = align_ff;
      count_in = count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_BASE_ADDRESS: base_in  = csr_data;
            REG_BLOCK_BYTES:  bytes_in = csr_data[7:0];
            REG_ALIGNMENT:    align_in = csr_data[7:0];
            REG_BLOCK_COUNT:  count_in = csr_data[8:0];
            default:          base_in  = base_ff;
         endcase
      end
   end

   // alignment rounded down to a power of two, zero acts as one
   always_comb begin
      msb = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (align_ff[i]) msb = 3'(i);
      end
      mask = 8'((9'd1 << msb) - 9'd1);
      aligned_in = (base_ff + {24'd0, mask}) & ~{24'd0, mask};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= RST_BASE_ADDRESS;
         bytes_ff   <= RST_BLOCK_BYTES;
         align_ff   <= RST_ALIGNMENT;
         count_ff   <= RST_BLOCK_COUNT;
         aligned_ff <= RST_BASE_ADDRESS;
      end else begin
         base_ff    <= base_in;
         bytes_ff   <= bytes_in;
         align_ff   <= align_in;
         count_ff   <= count_in;
         aligned_ff <= aligned_in;
      end
   end

   // effective count is clipped to the link memory depth
   assign cfg.aligned_base = aligned_ff;
   assign cfg.block_bytes  = bytes_ff;
   assign cfg.eff_count    = (count_ff > DEPTH_CAP) ? DEPTH_CAP : count_ff;

endmodule

`default_nettype wire

### hdl/fbpa_link_mem.sv
`default_nettype none

module fbpa_link_mem
   import fbpa_pkg::*;
#(
   parameter int unsigned DEPTH = LINK_SPAN,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [8:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [8:0]         rd_data
);

   logic [8:0] mem [DEPTH];
   logic [8:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/fbpa_checker.sv
`default_nettype none
`include "fixed_block_pool_allocator_core_macros.svh"

module fbpa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [1:0]  csr_index,
   input wire logic [31:0] csr_data
);

   logic        rsp_fire;
   logic [8:0]  blocks_now;
   logic [15:0] bytes_now;
   logic [9:0]  blocks_up;
   logic [9:0]  blocks_dn;
   logic        seen_ff, seen_in;
   logic [8:0]  prev_blocks_ff, prev_blocks_in;
   logic [15:0] prev_bytes_ff, prev_bytes_in;
   logic        unused_ok;

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign blocks_now = rsp_tdata[48:40];
   assign bytes_now  = rsp_tdata[64:49];
   assign blocks_up  = {1'b0, prev_blocks_ff} + 10'd1;
   assign blocks_dn  = {1'b0, blocks_now} + 10'd1;
   assign unused_ok  = req_tvalid | req_tready | (|req_tdata) | (|req_tuser) |
                       csr_valid | csr_ready | (|csr_index) | (|csr_data);

   // counts of the last response transfer
   always_comb begin
      seen_in        = seen_ff || rsp_fire;
      prev_blocks_in = rsp_fire ? blocks_now : prev_blocks_ff;
      prev_bytes_in  = rsp_fire ? bytes_now : prev_bytes_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff        <= 1'b0;
         prev_blocks_ff <= 9'd0;
         prev_bytes_ff  <= 16'd0;
      end else begin
         seen_ff        <= seen_in;
         prev_blocks_ff <= prev_blocks_in;
         prev_bytes_ff  <= prev_bytes_in;
      end
   end

   // a stalled response holds
   `FBPA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready && unused_ok | rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")

   // a failed allocate grants nothing
   `FBPA_ASSERT_IMP(a_fail_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[39:0] == 40'd0, "failed allocate carries a grant")

   // live block count moves by at most one, or restarts at zero
   `FBPA_ASSERT_IMP(a_count_step, clock, reset, rsp_fire && seen_ff, blocks_now == 9'd0 || blocks_now == prev_blocks_ff || {1'b0, blocks_now} == blocks_up || blocks_dn == {1'b0, prev_blocks_ff}, "live block count jumped")

   // a failed allocate leaves the counts alone
   `FBPA_ASSERT_IMP(a_fail_counts, clock, reset, rsp_fire && rsp_tuser && seen_ff, blocks_now == prev_blocks_ff && bytes_now == prev_bytes_ff, "failed allocate changed the counts")

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (.*);

`default_nettype wire

### tb/sv/fixed_block_pool_allocator_core_tb.sv
module fixed_block_pool_allocator_core_tb;
   import fbpa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned POOL_BLOCKS  = DEFAULT_NUM_BLOCKS;
   localparam int          PHASES       = 10;
   localparam int          RANDOM_ITEMS = 1825;
   localparam int          SETTLE       = 6;
   localparam int          CALM_TAIL    = 150;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          PRINT_CAP    = 30;

   // allocator state plus the configuration it runs with
   typedef struct packed {
      logic [31:0]                base;
      logic [7:0]                 bytes;
      logic [7:0]                 align;
      logic [8:0]                 count;
      logic [LINK_SPAN-1:0][8:0]  link;
      logic [8:0]                 head;
      logic [8:0]                 live_n;
      logic [15:0]                live_b;
   } pool_t;

   // one response transfer
   typedef struct packed {
      logic        status;
      logic [7:0]  blk;
      logic [31:0] addr;
      logic [8:0]  live_n;
      logic [15:0] live_b;
   } reply_t;

   typedef enum logic {STIM_REQ, STIM_CSR} stim_kind_e;

   typedef struct packed {
      stim_kind_e  kind;
      logic [1:0]  cmd;
      logic [7:0]  idx;
      logic [1:0]  reg_sel;
      logic [31:0] data;
   } stim_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] block_index
   logic [1:0]  req_tuser = CMD_NOP;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;   // [7:0] index, [39:8] address, [48:40] blocks, [64:49] bytes
   logic        rsp_tuser;   // [0] status
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_BASE_ADDRESS;
   logic [31:0] csr_data = '0;

   stim_t  stim_q[$];
   reply_t pool_replies[$];
   pool_t  pool;
   pool_t  plan;
   logic [7:0] held[$];

   int  items_sent = 0;
   int  results_seen = 0;
   int  errors = 0;
   int  cycle_count = 0;
   logic calm = 1'b0;
   int  n_grants = 0;
   int  n_exhausted = 0;
   int  n_frees = 0;
   int  n_inits = 0;
   int  n_nops = 0;
   int  n_csr = 0;

   fixed_block_pool_allocator_core #(
      .NUM_BLOCKS(POOL_BLOCKS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // state right after reset: empty free list, reset configuration
   function automatic pool_t pool_reset();
      pool_t p;
      p        = '0;
      p.base   = RST_BASE_ADDRESS;
      p.bytes  = RST_BLOCK_BYTES;
      p.align  = RST_ALIGNMENT;
      p.count  = RST_BLOCK_COUNT;
      p.head   = LINK_END;
      return p;
   endfunction

   function automatic pool_t pool_set_reg(input pool_t p, input logic [1:0] sel,
                                          input logic [31:0] value);
      case (sel)
         REG_BASE_ADDRESS: p.base  = value;
         REG_BLOCK_BYTES:  p.bytes = value[7:0];
         REG_ALIGNMENT:    p.align = value[7:0];
         REG_BLOCK_COUNT:  p.count = value[8:0];
         default: ;
      endcase
      return p;
   endfunction

   // next pool state and the response for one command
   function automatic pool_t pool_step(input pool_t p, input logic [1:0] cmd,
                                       input logic [7:0] idx, output reply_t r);
      int unsigned n;
      int unsigned i;
      int unsigned a;
      int unsigned sum;
      logic [31:0] mask;
      logic [31:0] abase;
      n = p.count;
      if (n > POOL_BLOCKS) n = POOL_BLOCKS;
      if (n > LINK_SPAN) n = LINK_SPAN;
      r = '0;
      case (cmd)
         CMD_INIT: begin
            for (i = 0; i < n; i++)
               p.link[i] = (i + 1 < n) ? 9'(i + 1) : LINK_END;
            p.head   = (n > 0) ? 9'd0 : LINK_END;
            p.live_n = '0;
            p.live_b = '0;
         end
         CMD_ALLOC: begin
            if (p.head[8]) begin
               r.status = 1'b1;
            end else begin
               // alignment rounded down to a power of two, capped at 128
               a = 1;
               while (a <= 64 && (a << 1) <= p.align) a = a << 1;
               mask   = 32'(a - 1);
               abase  = p.base + mask;
               abase  = abase & ~mask;
               r.blk  = p.head[7:0];
               r.addr = abase + {24'd0, r.blk} * {24'd0, p.bytes};
               p.head = p.link[p.head[7:0]];
               p.live_n = (p.live_n < 9'd511) ? p.live_n + 9'd1 : 9'd511;
               sum = p.live_b + p.bytes;
               p.live_b = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
            end
         end
         CMD_FREE: begin
            if (idx < n) begin
               p.link[idx] = p.head;
               p.head      = {1'b0, idx};
               p.live_n    = (p.live_n > 0) ? p.live_n - 9'd1 : 9'd0;
               p.live_b    = (p.live_b > {8'd0, p.bytes}) ? p.live_b - {8'd0, p.bytes}
                                                          : 16'd0;
            end
         end
         default: ;
      endcase
      r.live_n = p.live_n;
      r.live_b = p.live_b;
      return p;
   endfunction

   task automatic flag_error(input string what);
      if (errors < PRINT_CAP)
         $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
   endtask

   // queue a command and follow its effect on the planned pool
   task automatic plan_req(input logic [1:0] cmd, input logic [7:0] idx);
      stim_t  s;
      reply_t r;
      s.kind    = STIM_REQ;
      s.cmd     = cmd;
      s.idx     = idx;
      s.reg_sel = REG_BASE_ADDRESS;
      s.data    = '0;
      stim_q.push_back(s);
      plan = pool_step(plan, cmd, idx, r);
      if (cmd == CMD_INIT)
         held.delete();
      else if (cmd == CMD_ALLOC && !r.status)
         held.push_back(r.blk);
   endtask

   task automatic plan_csr(input logic [1:0] sel, input logic [31:0] value);
      stim_t s;
      s.kind    = STIM_CSR;
      s.cmd     = CMD_NOP;
      s.idx     = '0;
      s.reg_sel = sel;
      s.data    = value;
      stim_q.push_back(s);
      plan = pool_set_reg(plan, sel, value);
   endtask

   task automatic plan_config(input logic [31:0] base, input logic [7:0] bytes,
                              input logic [7:0] align, input logic [8:0] count);
      plan_csr(REG_BASE_ADDRESS, base);
      plan_csr(REG_BLOCK_BYTES, {24'd0, bytes});
      plan_csr(REG_ALIGNMENT, {24'd0, align});
      plan_csr(REG_BLOCK_COUNT, {23'd0, count});
   endtask

   // request driver: commands in order, register writes only once drained
   always @(posedge clock) begin : drive_requests
      stim_t  s;
      reply_t r;
      logic   v_req;
      logic   v_csr;
      int     gap_left;
      int     gap_pct;
      int     settle;
      int     popped;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid  <= 1'b0;
         pool     = pool_reset();
         gap_left = 0;
         gap_pct  = 0;
         settle   = 0;
         popped   = 0;
      end else begin
         v_req = req_tvalid;
         v_csr = csr_valid;
         // command transfer: predict its response
         if (req_tvalid && req_tready) begin
            pool = pool_step(pool, req_tuser, req_tdata, r);
            pool_replies.push_back(r);
            items_sent <= items_sent + 1;
            case (req_tuser)
               CMD_INIT:  n_inits++;
               CMD_ALLOC: if (r.status) n_exhausted++; else n_grants++;
               CMD_FREE:  n_frees++;
               default:   n_nops++;
            endcase
            v_req = 1'b0;
         end
         // register transfer
         if (csr_valid && csr_ready) begin
            pool = pool_set_reg(pool, csr_index, csr_data);
            n_csr++;
            v_csr = 1'b0;
         end
         if (!v_req && !v_csr) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (stim_q.size() != 0) begin
               s = stim_q[0];
               if (s.kind == STIM_REQ) begin
                  void'(stim_q.pop_front());
                  req_tuser <= s.cmd;
                  req_tdata <= s.idx;
                  v_req = 1'b1;
                  if (popped % 64 == 0) begin
                     case ($urandom_range(0, 3))
                        0:       gap_pct = 0;
                        1:       gap_pct = 10;
                        2:       gap_pct = 30;
                        default: gap_pct = 60;
                     endcase
                  end
                  popped++;
                  if (!calm && $urandom_range(0, 99) < gap_pct)
                     gap_left = $urandom_range(1, 5);
               end else if (!req_tvalid && results_seen == items_sent) begin
                  // pool drained: let it settle, then write
                  if (settle < SETTLE) begin
                     settle++;
                  end else begin
                     settle = 0;
                     void'(stim_q.pop_front());
                     csr_index <= s.reg_sel;
                     csr_data  <= s.data;
                     v_csr = 1'b1;
                  end
               end else begin
                  settle = 0;
               end
            end
         end
         req_tvalid <= v_req;
         csr_valid  <= v_csr;
         calm       <= (stim_q.size() < CALM_TAIL);
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin : check_replies
      reply_t want;
      reply_t got;
      int     stall_left;
      int     stall_pct;
      int     accepted;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         stall_pct  = 0;
         accepted   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.blk    = rsp_tdata[7:0];
            got.addr   = rsp_tdata[39:8];
            got.live_n = rsp_tdata[48:40];
            got.live_b = rsp_tdata[64:49];
            if (results_seen >= items_sent) begin
               flag_error($sformatf("reply %0d with no command outstanding", results_seen));
            end else begin
               want = pool_replies.pop_front();
               if (got.status !== want.status)
                  flag_error($sformatf("reply %0d status %0b, want %0b",
                                       results_seen, got.status, want.status));
               if (got.blk !== want.blk)
                  flag_error($sformatf("reply %0d index %0d, want %0d",
                                       results_seen, got.blk, want.blk));
               if (got.addr !== want.addr)
                  flag_error($sformatf("reply %0d address %h, want %h",
                                       results_seen, got.addr, want.addr));
               if (got.live_n !== want.live_n)
                  flag_error($sformatf("reply %0d live blocks %0d, want %0d",
                                       results_seen, got.live_n, want.live_n));
               if (got.live_b !== want.live_b)
                  flag_error($sformatf("reply %0d live bytes %0d, want %0d",
                                       results_seen, got.live_b, want.live_b));
            end
            if (rsp_tdata[71:65] !== '0)
               flag_error($sformatf("reply %0d pad bits %h", results_seen, rsp_tdata[71:65]));
            results_seen <= results_seen + 1;
            accepted++;
            if (accepted % 48 == 0) begin
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 10;
                  2:       stall_pct = 30;
                  default: stall_pct = 60;
               endcase
            end
         end
         // random stall bursts, none while calm
         if (calm) begin
            stall_left = 0;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d replies seen",
                  cycle_count, results_seen, items_sent);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : run_test
      int          p;
      int          k;
      int          roll;
      int          alloc_pct;
      int          per_phase;
      int          pos;
      logic [7:0]  idx;
      logic [31:0] base;
      logic [7:0]  bytes;
      logic [7:0]  align;
      logic [8:0]  count;

      plan = pool_reset();

      // reset configuration, list not yet built
      plan_req(CMD_ALLOC, 8'hFF);      // allocate before init
      plan_req(CMD_NOP, 8'hA5);
      plan_req(CMD_FREE, 8'h00);       // free with nothing live, counts stay at zero
      plan_req(CMD_ALLOC, 8'h00);      // grants the block just pushed
      plan_req(CMD_ALLOC, 8'h5A);      // list empty again
      plan_req(CMD_INIT, 8'h00);
      plan_req(CMD_ALLOC, 8'h00);
      plan_req(CMD_ALLOC, 8'h00);
      plan_req(CMD_FREE, 8'hFF);       // top index of a full pool
      plan_req(CMD_ALLOC, 8'h00);
      plan_req(CMD_FREE, 8'h01);
      plan_req(CMD_FREE, 8'h01);       // double free pushes it twice
      plan_req(CMD_ALLOC, 8'h00);
      plan_req(CMD_ALLOC, 8'h00);

      // two-block pool near the top of the address space, address wraps
      plan_config(32'hFFFF_FF01, 8'd255, 8'd128, 9'd2);
      plan_req(CMD_INIT, 8'hFF);
      plan_req(CMD_ALLOC, 8'h00);
      plan_req(CMD_ALLOC, 8'h00);
      plan_req(CMD_ALLOC, 8'h00);      // exhausted
      plan_req(CMD_FREE, 8'h02);       // beyond block count, ignored
      plan_req(CMD_FREE, 8'hFF);       // ignored
      plan_req(CMD_FREE, 8'h00);
      plan_req(CMD_FREE, 8'h01);
      plan_req(CMD_FREE, 8'h01);       // counts saturate at zero
      plan_req(CMD_ALLOC, 8'h00);

      // random phases, each with its own configuration
      per_phase = RANDOM_ITEMS / PHASES;
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               base = 32'hFFFF_FFFF; bytes = 8'd255; align = 8'd1; count = 9'd256;
            end
            1: begin
               base = 32'd0; bytes = 8'd1; align = 8'd128; count = 9'd1;
            end
            2: begin
               base = $urandom; bytes = 8'($urandom_range(1, 255)); align = 8'd128;
               count = 9'd256;
            end
            default: begin
               base  = $urandom;
               bytes = 8'($urandom_range(1, 255));
               align = 8'(1 << $urandom_range(0, 7));
               count = ($urandom_range(0, 3) == 0) ? 9'd256 : 9'($urandom_range(1, 48));
            end
         endcase
         plan_config(base, bytes, align, count);
         // now and then keep the old list under a new configuration
         if (p < 3 || $urandom_range(0, 4) != 0)
            plan_req(CMD_INIT, 8'($urandom_range(0, 255)));
         alloc_pct = $urandom_range(40, 60);
         for (k = 0; k < per_phase; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct) begin
               plan_req(CMD_ALLOC, 8'($urandom_range(0, 255)));
            end else if (roll < 92) begin
               if (held.size() != 0) begin
                  pos = $urandom_range(0, held.size() - 1);
                  idx = held[pos];
                  held.delete(pos);
                  plan_req(CMD_FREE, idx);
               end else begin
                  plan_req(CMD_ALLOC, 8'($urandom_range(0, 255)));
               end
            end else if (roll < 95) begin
               // stray free: out of range or a second free
               plan_req(CMD_FREE, 8'($urandom_range(0, 255)));
            end else if (roll < 98) begin
               plan_req(CMD_NOP, 8'($urandom_range(0, 255)));
            end else begin
               plan_req(CMD_INIT, 8'($urandom_range(0, 255)));
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wait for the last command and its response
      do @(negedge clock);
      while (!(stim_q.size() == 0 && !req_tvalid && !csr_valid && results_seen == items_sent));
      repeat (300) @(negedge clock);
      if (pool_replies.size() != 0)
         flag_error($sformatf("%0d responses never arrived", pool_replies.size()));

      $display("covered %0d commands: %0d grants, %0d exhausted, %0d frees, %0d inits, %0d no-ops",
               items_sent, n_grants, n_exhausted, n_frees, n_inits, n_nops);
      $display("%0d register writes, %0d responses checked, %0d mismatches",
               n_csr, results_seen, errors);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### fixed_block_pool_allocator_core.f
+incdir+hdl
hdl/fbpa_pkg.sv
hdl/fbpa_csr.sv
hdl/fbpa_link_mem.sv
hdl/fixed_block_pool_allocator_core.sv
hdl/fbpa_checker.sv
tb/sv/fixed_block_pool_allocator_core_tb.sv
